/* rtl/btls_pkg.sv */
// types and constants shared by the traffic light sequencer modules
`default_nettype none

package btls_pkg;

  // mode encoding of the light cycle
  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_ON        = 3'd1,
    MODE_GREEN     = 3'd2,
    MODE_YEL_RED   = 3'd3,
    MODE_RED       = 3'd4,
    MODE_YEL_GREEN = 3'd5,
    MODE_TO_OFF    = 3'd6
  } mode_t;

  // one poll: button level and coarse time
  typedef struct packed {
    logic        button_pressed;
    logic [15:0] time_seconds;
  } in_word_t;

  // latched lamp levels, also the result word
  typedef struct packed {
    logic green_lamp;
    logic yellow_lamp;
    logic red_lamp;
    logic arrow_lamp;
  } out_word_t;

  // controller state carried from poll to poll
  typedef struct packed {
    mode_t       mode;
    logic [15:0] last_release_time;
    logic        arrow_done;
    logic        arrow_parity;
    out_word_t   lamps;
  } state_t;

  localparam logic [7:0] LONG_PRESS_RESET = 8'd5;

endpackage

`default_nettype wire

/* rtl/btls_step.sv */
// next-state logic for one poll of the traffic light sequencer
`default_nettype none

module btls_step (
  input  btls_pkg::state_t   state,
  input  btls_pkg::in_word_t word,
  input  logic [7:0]         long_press_seconds,
  output btls_pkg::state_t   state_next
);

  logic        pressed;
  logic [15:0] held;
  logic        long_hold;
  btls_pkg::mode_t mode_eff;

  // release time tracking and long hold detection
  always_comb begin
    pressed   = word.button_pressed;
    held      = word.time_seconds - state.last_release_time;
    long_hold = pressed && (held >= {8'd0, long_press_seconds});
    mode_eff  = long_hold ? btls_pkg::MODE_TO_OFF : state.mode;
  end

  // mode actions
  always_comb begin
    state_next      = state;
    state_next.mode = mode_eff;
    if (!pressed) begin
      state_next.last_release_time = word.time_seconds;
    end
    case (mode_eff)
      btls_pkg::MODE_TO_OFF: begin
        if (pressed) begin
          state_next.lamps.green_lamp  = 1'b0;
          state_next.lamps.yellow_lamp = 1'b0;
          state_next.lamps.red_lamp    = 1'b0;
        end else begin
          state_next.mode = btls_pkg::MODE_OFF;
        end
      end
      btls_pkg::MODE_OFF: begin
        if (!pressed) begin
          state_next.lamps.yellow_lamp = word.time_seconds[0];
        end else begin
          state_next.mode = btls_pkg::MODE_ON;
        end
      end
      btls_pkg::MODE_ON: begin
        if (pressed) begin
          state_next.lamps.yellow_lamp = 1'b1;
        end else begin
          state_next.mode = btls_pkg::MODE_GREEN;
        end
      end
      btls_pkg::MODE_GREEN: begin
        if (!pressed) begin
          state_next.lamps.red_lamp    = 1'b0;
          state_next.lamps.yellow_lamp = 1'b0;
          state_next.lamps.green_lamp  = 1'b1;
        end else begin
          state_next.mode = btls_pkg::MODE_YEL_RED;
        end
      end
      btls_pkg::MODE_YEL_RED: begin
        if (pressed) begin
          state_next.lamps.green_lamp  = 1'b0;
          state_next.lamps.yellow_lamp = 1'b1;
        end else begin
          state_next.mode = btls_pkg::MODE_RED;
        end
      end
      btls_pkg::MODE_RED: begin
        if (!pressed) begin
          state_next.lamps.yellow_lamp = 1'b0;
          state_next.lamps.red_lamp    = 1'b1;
          // arrow on every other red entry
          if (!state.arrow_done) begin
            if (!state.arrow_parity) begin
              state_next.lamps.arrow_lamp = 1'b1;
            end
            state_next.arrow_parity = ~state.arrow_parity;
            state_next.arrow_done   = 1'b1;
          end
        end else begin
          state_next.mode       = btls_pkg::MODE_YEL_GREEN;
          state_next.arrow_done = 1'b0;
        end
      end
      btls_pkg::MODE_YEL_GREEN: begin
        if (pressed) begin
          state_next.lamps.arrow_lamp  = 1'b0;
          state_next.lamps.red_lamp    = 1'b1;
          state_next.lamps.yellow_lamp = 1'b1;
        end else begin
          state_next.mode = btls_pkg::MODE_GREEN;
        end
      end
      default: begin
        state_next.mode = mode_eff;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/button_traffic_light_sequencer.sv */
// top level of the button driven traffic light sequencer
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid / in_ready    | button level, coarse time
//   out     | output    | out_valid / out_ready  | green, yellow, red, arrow lamps
//   cfg     | input     | cfg_valid / cfg_ready  | long press threshold, 8 bits
//
// one word per cycle sustained while the output is not stalled; an accepted poll passes through
// the input register, then the state and lamp register updated by one pass of btls_step
// rst is synchronous: mode off, lamps dark, threshold 5, both registers empty
// a stalled output freezes the state; the input register still takes one word
// cfg_ready is always high
`default_nettype none

module button_traffic_light_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  btls_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btls_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic               in_full;
  btls_pkg::in_word_t in_word;
  logic [7:0]         long_press_seconds;
  btls_pkg::state_t   state;
  btls_pkg::state_t   state_next;
  logic               advance;
  logic               fire;

  // handshake control
  assign advance   = !out_valid || out_ready;
  assign fire      = in_full && advance;
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;
  assign out_data  = state.lamps;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_seconds <= btls_pkg::LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      long_press_seconds <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word <= in_data;
    end
  end

  // per-poll update
  btls_step u_step (
    .state              (state),
    .word               (in_word),
    .long_press_seconds (long_press_seconds),
    .state_next         (state_next)
  );

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode              <= btls_pkg::MODE_OFF;
      state.last_release_time <= 16'd0;
      state.arrow_done        <= 1'b0;
      state.arrow_parity      <= 1'b0;
      state.lamps             <= '0;
      out_valid               <= 1'b0;
    end else begin
      if (fire) begin
        state <= state_next;
      end
      if (advance) begin
        out_valid <= in_full;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a word held in the input register is not dropped while the output stalls
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> in_full)
    else $error("input word lost during stall");

  // every processed poll produces a result
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed poll gave no result");

  // state does not move while a result waits
  a_state_frozen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(state))
    else $error("state changed during output stall");

  // first released poll in red makes the arrow decision and flips parity
  a_arrow_once: assert property (@(posedge clk) disable iff (rst)
    (fire && !in_word.button_pressed && state.mode == btls_pkg::MODE_RED
     && !state.arrow_done)
    |=> (state.arrow_done && state.arrow_parity != $past(state.arrow_parity)))
    else $error("arrow decision not recorded");
`endif

endmodule

`default_nettype wire
